@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the RTL top level of the modified UTF-8 decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mu8d_pkg.sv @@
// Types and constants of the modified UTF-8 decoder.
package mu8d_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned HELD_W = 40;
  localparam int unsigned NEED_W = 3;

  localparam logic [7:0]      BYTE_ED      = 8'hED;
  localparam logic [3:0]      NIB_SUR_HI   = 4'hA;
  localparam logic [3:0]      NIB_SUR_LO   = 4'hB;
  localparam logic [CP_W-1:0] SUPP_BASE    = 21'h10000;

  // Open sequence kind, one-hot.
  typedef enum logic [3:0] {
    KIND_NONE  = 4'b0001,
    KIND_TWO   = 4'b0010,
    KIND_THREE = 4'b0100,
    KIND_SIX   = 4'b1000
  } seq_kind_t;

  typedef struct packed {
    logic [NEED_W-1:0] bytes_needed;
    seq_kind_t         kind;
    logic [HELD_W-1:0] held;
    logic              skipping;
  } dec_state_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            bad_encoding;
    logic            string_done;
  } dec_result_t;

  localparam dec_state_t ST_RESET = '{
    bytes_needed: '0,
    kind:         KIND_NONE,
    held:         '0,
    skipping:     1'b0
  };

endpackage

@@ rtl/core/mu8d_decode.sv @@
// Per-byte decode step: next sequence state and the optional result.
module mu8d_decode
  import mu8d_pkg::*;
(
  input  dec_state_t  st,
  input  logic [7:0]  in_b,
  input  logic        in_eos,
  output dec_state_t  st_nxt,
  output logic        res_valid,
  output dec_result_t res
);

  logic              do_fail;
  logic              do_emit;
  logic [CP_W-1:0]   emit_cp;
  logic              ok;
  seq_kind_t         kind_w;
  logic [NEED_W-1:0] need_w;
  logic [NEED_W-1:0] need_d;
  logic [HELD_W-1:0] held_w;
  logic              is_cont;

  assign is_cont = (in_b[7:6] == 2'b10);
  assign held_w  = {st.held[HELD_W-9:0], in_b};
  assign need_d  = need_w - NEED_W'(1);

  always_comb begin
    st_nxt  = st;
    do_fail = 1'b0;
    do_emit = 1'b0;
    emit_cp = '0;
    ok      = 1'b0;
    kind_w  = st.kind;
    need_w  = st.bytes_needed;

    if (st.skipping) begin
      if (in_eos) begin
        st_nxt.skipping = 1'b0;
      end
    end else if (st.kind == KIND_NONE) begin
      if (in_b == 8'h00 || in_b[7:6] == 2'b10 || in_b[7:4] == 4'hF) begin
        do_fail = 1'b1;
      end else if (!in_b[7]) begin
        do_emit = 1'b1;
        emit_cp = CP_W'(in_b);
      end else begin
        if (in_b[7:5] == 3'b110) begin
          st_nxt.kind         = KIND_TWO;
          st_nxt.bytes_needed = NEED_W'(1);
        end else begin
          st_nxt.kind         = KIND_THREE;
          st_nxt.bytes_needed = NEED_W'(2);
        end
        st_nxt.held = HELD_W'(in_b);
        do_fail     = in_eos;
      end
    end else begin
      case (st.kind)
        KIND_TWO: begin
          ok = is_cont;
        end
        KIND_THREE: begin
          // A lead of ED followed by Ax opens the six-byte surrogate form.
          if (st.bytes_needed == NEED_W'(2) && st.held[7:0] == BYTE_ED &&
              in_b[7:4] == NIB_SUR_HI) begin
            kind_w = KIND_SIX;
            need_w = NEED_W'(5);
            ok     = 1'b1;
          end else begin
            ok = is_cont;
          end
        end
        KIND_SIX: begin
          case (st.bytes_needed)
            3'd4:    ok = is_cont;
            3'd3:    ok = (in_b == BYTE_ED);
            3'd2:    ok = (in_b[7:4] == NIB_SUR_LO);
            3'd1:    ok = is_cont;
            default: ok = 1'b0;
          endcase
        end
        default: ok = 1'b0;
      endcase

      if (!ok || need_w == '0) begin
        do_fail = 1'b1;
      end else if (need_d != '0) begin
        st_nxt.kind         = kind_w;
        st_nxt.bytes_needed = need_d;
        st_nxt.held         = held_w;
        do_fail             = in_eos;
      end else begin
        do_emit = 1'b1;
        case (kind_w)
          KIND_TWO: begin
            emit_cp = {10'b0, held_w[12:8], held_w[5:0]};
          end
          KIND_THREE: begin
            emit_cp = {5'b0, held_w[19:16], held_w[13:8], held_w[5:0]};
          end
          default: begin
            emit_cp = SUPP_BASE + {1'b0, held_w[35:32], 16'b0}
                    + {5'b0, held_w[29:24], 10'b0}
                    + {11'b0, held_w[11:8], 6'b0}
                    + {15'b0, held_w[5:0]};
          end
        endcase
        st_nxt.kind         = KIND_NONE;
        st_nxt.bytes_needed = '0;
        st_nxt.held         = '0;
      end
    end

    res_valid        = do_fail | do_emit;
    res.code_point   = do_fail ? '0 : emit_cp;
    res.bad_encoding = do_fail;
    res.string_done  = do_fail | in_eos;

    if (do_fail) begin
      st_nxt.kind         = KIND_NONE;
      st_nxt.bytes_needed = '0;
      st_nxt.held         = '0;
      st_nxt.skipping     = !in_eos;
    end
  end

endmodule

@@ rtl/core/modified_utf8_decoder_top.sv @@
// Top level of the modified UTF-8 decoder: input register, decode step, result register.
//
// The input channel carries one byte of a modified UTF-8 string per transaction,
// with in_end_of_string marking the final byte of a string. The result channel
// carries one code point per completed character, or one error result that
// closes a malformed string; the remaining bytes of that string give nothing.
// Surrogate pairs in the six-byte ED Ax xx ED Bx xx form come out as one code point.
//
// Throughput is one byte per cycle while the result channel is not stalled. A byte
// accepted into the input register is decoded from it combinationally, and its
// result is captured in the result register when the pipeline advances. The single
// sequence state register is updated as each byte leaves the input register.
//
// While the receiver stalls a waiting result, a new byte can still enter the
// input register; in_stall rises only when both the input register and the
// result register are full. Reset (rst_n low, synchronous) empties both
// registers and closes any open sequence and any skipping of a string.
module modified_utf8_decoder_top
  import mu8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            in_end_of_string,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_bad_encoding,
  output logic            out_string_done
);

`include "assert_macros.svh"

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_eos_r;
  dec_state_t  st_r;
  dec_state_t  st_nxt;
  logic        out_valid_r;
  dec_result_t out_res_r;
  logic        res_valid;
  dec_result_t res;
  logic        advance;

  assign advance  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !advance;

  mu8d_decode u_decode (
    .st        (st_r),
    .in_b      (s1_byte_r),
    .in_eos    (s1_eos_r),
    .st_nxt    (st_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      st_r        <= ST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        st_r        <= st_nxt;
        out_valid_r <= res_valid;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r <= in_byte;
      s1_eos_r  <= in_end_of_string;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_point   = out_res_r.code_point;
  assign out_bad_encoding = out_res_r.bad_encoding;
  assign out_string_done  = out_res_r.string_done;

  `ASSERT_IMPLY(a_err_closes, clk, rst_n, out_valid_r && out_res_r.bad_encoding,
    out_res_r.string_done && out_res_r.code_point == '0, "error result not closing")
  `ASSERT_ALWAYS(a_skip_no_seq, clk, rst_n, !(st_r.skipping && st_r.kind != KIND_NONE),
    "skipping while a sequence is open")
  `ASSERT_IMPLY(a_none_empty, clk, rst_n, st_r.kind == KIND_NONE,
    st_r.bytes_needed == '0 && st_r.held == '0, "idle sequence state not cleared")
  `ASSERT_IMPLY(a_stall_full, clk, rst_n, in_stall, s1_valid_r && out_valid_r,
    "input stalled with a free register")

endmodule

@@ tb/tb_modified_utf8_decoder_top.sv @@
// Self-checking testbench of the modified UTF-8 decoder: a directed byte table, then random strings.
module tb_modified_utf8_decoder_top
  import mu8d_pkg::*;
();

  localparam int BYTE_TARGET    = 650;
  localparam int WATCHDOG_LIMIT = 200;
  localparam int TAIL_CYCLES    = 8;
  localparam int REPORT_LIMIT   = 10;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_RESULT
  } row_chk_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eos;
    row_chk_t    chk;
    dec_result_t res;
  } dir_row_t;

  localparam dec_result_t BAD_RES  = '{code_point: '0, bad_encoding: 1'b1, string_done: 1'b1};
  localparam dec_result_t NULL_RES = '0;
  localparam int          DIR_ROWS = 27;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{8'h00, 1'b1, CHK_RESULT, BAD_RES},
    '{8'h01, 1'b0, CHK_RESULT, '{21'h1, 1'b0, 1'b0}},
    '{8'h7F, 1'b1, CHK_RESULT, '{21'h7F, 1'b0, 1'b1}},
    '{8'hF0, 1'b0, CHK_RESULT, BAD_RES},
    '{8'h41, 1'b0, CHK_NONE,   NULL_RES},
    '{8'h80, 1'b1, CHK_NONE,   NULL_RES},
    '{8'hC0, 1'b0, CHK_NONE,   NULL_RES},
    '{8'h80, 1'b1, CHK_MODEL,  NULL_RES},
    '{8'hDF, 1'b0, CHK_NONE,   NULL_RES},
    '{8'hBF, 1'b0, CHK_MODEL,  NULL_RES},
    '{8'hED, 1'b0, CHK_NONE,   NULL_RES},
    '{8'h9F, 1'b0, CHK_NONE,   NULL_RES},
    '{8'hBF, 1'b0, CHK_MODEL,  NULL_RES},
    '{8'hED, 1'b0, CHK_NONE,   NULL_RES},
    '{8'hAF, 1'b0, CHK_NONE,   NULL_RES},
    '{8'hBF, 1'b0, CHK_NONE,   NULL_RES},
    '{8'hED, 1'b0, CHK_NONE,   NULL_RES},
    '{8'hBF, 1'b0, CHK_NONE,   NULL_RES},
    '{8'hBF, 1'b1, CHK_MODEL,  NULL_RES},
    '{8'hE0, 1'b1, CHK_RESULT, BAD_RES},
    '{8'hC3, 1'b0, CHK_NONE,   NULL_RES},
    '{8'h41, 1'b1, CHK_RESULT, BAD_RES},
    '{8'hED, 1'b0, CHK_NONE,   NULL_RES},
    '{8'hA0, 1'b0, CHK_NONE,   NULL_RES},
    '{8'h80, 1'b0, CHK_NONE,   NULL_RES},
    '{8'h41, 1'b0, CHK_RESULT, BAD_RES},
    '{8'h00, 1'b1, CHK_NONE,   NULL_RES}
  };

  logic            clk              = 1'b0;
  logic            rst_n            = 1'b0;
  logic            in_valid         = 1'b0;
  logic            in_stall;
  logic [7:0]      in_byte          = 8'h00;
  logic            in_end_of_string = 1'b0;
  logic            out_valid;
  logic            out_stall        = 1'b0;
  logic [CP_W-1:0] out_code_point;
  logic            out_bad_encoding;
  logic            out_string_done;

  // Decoder state as the predictor tracks it.
  logic [NEED_W-1:0] need_cnt;
  seq_kind_t         open_kind;
  logic [HELD_W-1:0] seq_bytes;
  logic              drop_rest;

  dec_result_t pending_results[$];
  logic [7:0]  str_bytes[$];

  int fail_count;
  int results_checked;
  int bytes_sent;
  int bytes_decoded;
  int strings_sent;
  int bad_predicted;
  int supp_predicted;
  int in_left;
  int out_left;
  bit in_calm;
  bit out_calm;

  modified_utf8_decoder_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_point   (out_code_point),
    .out_bad_encoding (out_bad_encoding),
    .out_string_done  (out_string_done)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_open_seq();
    need_cnt  = '0;
    open_kind = KIND_NONE;
    seq_bytes = '0;
  endfunction

  function automatic bit flag_bad(input logic eos, output dec_result_t r);
    clear_open_seq();
    drop_rest = !eos;
    r = BAD_RES;
    return 1'b1;
  endfunction

  // Advances the predicted decoder by one byte; returns 1 when a result is due.
  function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                     output dec_result_t r);
    logic        ok;
    int unsigned cp;
    r = '0;
    if (drop_rest) begin
      if (eos) drop_rest = 1'b0;
      return 1'b0;
    end
    if (open_kind == KIND_NONE) begin
      if (b == 8'h00 || (b >= 8'h80 && b < 8'hC0) || b >= 8'hF0) return flag_bad(eos, r);
      if (b < 8'h80) begin
        r.code_point  = CP_W'(b);
        r.string_done = eos;
        return 1'b1;
      end
      if (b < 8'hE0) begin
        open_kind = KIND_TWO;
        need_cnt  = 3'd1;
      end else begin
        open_kind = KIND_THREE;
        need_cnt  = 3'd2;
      end
      seq_bytes = HELD_W'(b);
      if (eos) return flag_bad(eos, r);
      return 1'b0;
    end
    case (open_kind)
      KIND_TWO: ok = (b[7:6] == 2'b10);
      KIND_THREE: begin
        // ED followed by Ax switches to the six-byte surrogate form.
        if (need_cnt == 3'd2 && seq_bytes[7:0] == BYTE_ED && b[7:4] == NIB_SUR_HI) begin
          open_kind = KIND_SIX;
          need_cnt  = 3'd5;
          ok        = 1'b1;
        end else begin
          ok = (b[7:6] == 2'b10);
        end
      end
      default: begin
        case (need_cnt)
          3'd4:    ok = (b[7:6] == 2'b10);
          3'd3:    ok = (b == BYTE_ED);
          3'd2:    ok = (b[7:4] == NIB_SUR_LO);
          3'd1:    ok = (b[7:6] == 2'b10);
          default: ok = 1'b0;
        endcase
      end
    endcase
    if (!ok || need_cnt == '0) return flag_bad(eos, r);
    seq_bytes = {seq_bytes[HELD_W-9:0], b};
    need_cnt  = need_cnt - 3'd1;
    if (need_cnt != '0) begin
      if (eos) return flag_bad(eos, r);
      return 1'b0;
    end
    case (open_kind)
      KIND_TWO:   cp = 32'({seq_bytes[12:8], seq_bytes[5:0]});
      KIND_THREE: cp = 32'({seq_bytes[19:16], seq_bytes[13:8], seq_bytes[5:0]});
      default:    cp = 32'(SUPP_BASE) + (32'(seq_bytes[35:32]) << 16)
                     + (32'(seq_bytes[29:24]) << 10) + (32'(seq_bytes[11:8]) << 6)
                     + 32'(seq_bytes[5:0]);
    endcase
    clear_open_seq();
    r.code_point  = cp[CP_W-1:0];
    r.string_done = eos;
    return 1'b1;
  endfunction

  // Alternates calm stretches without waits with stretches of random waits.
  function automatic int draw_wait(inout int left, inout bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      left = $urandom_range(8, 40);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endtask

  task automatic check_result(input dec_result_t got);
    dec_result_t want;
    if (pending_results.size() == 0) begin
      note_fail($sformatf("unexpected result cp=%h bad=%b done=%b",
                          got.code_point, got.bad_encoding, got.string_done));
    end else begin
      want = pending_results.pop_front();
      if (got !== want)
        note_fail($sformatf("result %0d: expected cp=%h bad=%b done=%b, got cp=%h bad=%b done=%b",
                            results_checked, want.code_point, want.bad_encoding,
                            want.string_done, got.code_point, got.bad_encoding,
                            got.string_done));
    end
    results_checked++;
  endtask

  function automatic void note_expected(input dec_result_t r);
    pending_results.push_back(r);
    if (r.bad_encoding) bad_predicted++;
    if (r.code_point >= SUPP_BASE) supp_predicted++;
  endfunction

  // Presents one byte and returns at the edge where the transaction completes.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = draw_wait(in_left, in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_byte          <= b;
    in_end_of_string <= eos;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    bytes_sent++;
  endtask

  task automatic push_cont();
    str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  task automatic add_char();
    logic [7:0] lead;
    case ($urandom_range(0, 3))
      0: str_bytes.push_back(8'($urandom_range(8'h01, 8'h7F)));
      1: begin
        str_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        push_cont();
      end
      2: begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        str_bytes.push_back(lead);
        // Keep ED on the plain three-byte path here.
        if (lead == BYTE_ED) str_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
        else push_cont();
        push_cont();
      end
      default: begin
        str_bytes.push_back(BYTE_ED);
        str_bytes.push_back(8'($urandom_range(8'hA0, 8'hAF)));
        push_cont();
        str_bytes.push_back(BYTE_ED);
        str_bytes.push_back(8'($urandom_range(8'hB0, 8'hBF)));
        push_cont();
      end
    endcase
  endtask

  // Mostly well-formed strings, some with one damaged or missing byte, some pure noise.
  task automatic build_string();
    int pick;
    int n;
    str_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      n = $urandom_range(1, 5);
      repeat (n) add_char();
      if ($urandom_range(0, 99) < 15)
        str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 12 && str_bytes.size() > 1) void'(str_bytes.pop_back());
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) str_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic feed_byte(input logic [7:0] b, input logic eos, input row_chk_t chk,
                           input dec_result_t typed);
    dec_result_t r;
    bit          due;
    if (!drop_rest) bytes_decoded++;
    due = decode_byte(b, eos, r);
    case (chk)
      CHK_MODEL:  if (due) note_expected(r);
      CHK_RESULT: note_expected(typed);
      default:    ;
    endcase
    if (eos) strings_sent++;
    send_byte(b, eos);
  endtask

  initial begin : result_sink
    dec_result_t got;
    int          hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = draw_wait(out_left, out_calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(negedge clk); while (!out_valid);
      got = '{code_point: out_code_point, bad_encoding: out_bad_encoding,
              string_done: out_string_done};
      check_result(got);
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d results still due",
             WATCHDOG_LIMIT, pending_results.size());
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    fail_count      = 0;
    results_checked = 0;
    bytes_sent      = 0;
    bytes_decoded   = 0;
    strings_sent    = 0;
    bad_predicted   = 0;
    supp_predicted  = 0;
    in_left         = 0;
    out_left        = 0;
    drop_rest       = 1'b0;
    clear_open_seq();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      feed_byte(DIR_TABLE[i].data, DIR_TABLE[i].eos, DIR_TABLE[i].chk, DIR_TABLE[i].res);
    end

    while (bytes_sent < BYTE_TARGET) begin
      build_string();
      foreach (str_bytes[k]) begin
        feed_byte(str_bytes[k], k == str_bytes.size() - 1, CHK_MODEL, NULL_RES);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d strings, %0d decoded outside skipped tails",
             bytes_sent, strings_sent, bytes_decoded);
    $display("checked %0d results: %0d malformed-string errors, %0d supplementary code points",
             results_checked, bad_predicted, supp_predicted);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
